@@ sv/pus_pkg.sv @@
`default_nettype none
package pus_pkg;

	localparam int SRC_BYTES_PER_ROW = 40;
	localparam int SRC_ROWS          = 144;

	localparam int COL_W  = $clog2(SRC_BYTES_PER_ROW + 1);
	localparam int ROW_W  = $clog2(SRC_ROWS);
	localparam int DROW_W = 8;
	localparam int DCOL_W = 7;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHADE0 = 2'd0,
		REG_SHADE1 = 2'd1,
		REG_SHADE2 = 2'd2,
		REG_SHADE3 = 2'd3
	} cfg_reg_t;

	localparam logic [3:0] SHADE0_RST = 4'd15;
	localparam logic [3:0] SHADE1_RST = 4'd10;
	localparam logic [3:0] SHADE2_RST = 4'd5;
	localparam logic [3:0] SHADE3_RST = 4'd0;

	// One classified source word: three packed output bytes plus placement
	typedef struct packed {
		logic [7:0]        b0;
		logic [7:0]        b1;
		logic [7:0]        b2;
		logic [DROW_W-1:0] row;
		logic [DCOL_W-1:0] col;
		logic              dbl;
	} item_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage
`default_nettype wire

@@ sv/pus_in_if.sv @@
`default_nettype none
interface pus_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;

	modport source (output valid, output pixel_byte, input ready);
	modport sink (input valid, input pixel_byte, output ready);
endinterface
`default_nettype wire

@@ sv/pus_out_if.sv @@
`default_nettype none
interface pus_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [7:0] out_row;
	logic [6:0] out_col;
	logic       last;

	modport source (output valid, output out_byte, output out_row, output out_col,
		output last, input ready);
	modport sink (input valid, input out_byte, input out_row, input out_col,
		input last, output ready);
endinterface
`default_nettype wire

@@ sv/pus_front.sv @@
`default_nettype none
module pus_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	pus_in_if.sink                              in_ch,
	input  wire logic                           cfg_we,
	input  wire logic [pus_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [pus_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           full,
	output logic                                push,
	output pus_pkg::item_t                      item
);
	import pus_pkg::*;

	logic [3:0]        shade0_q, shade1_q, shade2_q, shade3_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [DROW_W-1:0] drow_q;
	logic [DCOL_W-1:0] dcol_q;
	logic [3:0]        c0, c1, c2, c3;
	logic              col_wrap, row_wrap;

	function automatic logic [3:0] map_shade(input logic [1:0] s, input logic [3:0] p0,
		input logic [3:0] p1, input logic [3:0] p2, input logic [3:0] p3);
		logic [3:0] r;
		case (s)
			2'd0: r = p0;
			2'd1: r = p1;
			2'd2: r = p2;
			default: r = p3;
		endcase
		return r;
	endfunction

	assign in_ch.ready = ~full;
	assign push        = in_ch.valid & ~full;

	assign c0 = map_shade(in_ch.pixel_byte[7:6], shade0_q, shade1_q, shade2_q, shade3_q);
	assign c1 = map_shade(in_ch.pixel_byte[5:4], shade0_q, shade1_q, shade2_q, shade3_q);
	assign c2 = map_shade(in_ch.pixel_byte[3:2], shade0_q, shade1_q, shade2_q, shade3_q);
	assign c3 = map_shade(in_ch.pixel_byte[1:0], shade0_q, shade1_q, shade2_q, shade3_q);

	always_comb begin
		item.b0  = {c0, c0};
		item.b1  = {c1, c2};
		item.b2  = {c2, c3};
		item.row = drow_q;
		item.col = dcol_q;
		item.dbl = ~row_q[0];
	end

	assign col_wrap = (col_q == COL_W'(SRC_BYTES_PER_ROW - 1));
	assign row_wrap = (row_q == ROW_W'(SRC_ROWS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shade0_q <= SHADE0_RST;
			shade1_q <= SHADE1_RST;
			shade2_q <= SHADE2_RST;
			shade3_q <= SHADE3_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_SHADE0: shade0_q <= cfg_wdata;
				REG_SHADE1: shade1_q <= cfg_wdata;
				REG_SHADE2: shade2_q <= cfg_wdata;
				REG_SHADE3: shade3_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Destination row/column track ceil(3*r/2) and 3*c incrementally
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			drow_q <= '0;
			dcol_q <= '0;
		end else if (push) begin
			if (col_wrap) begin
				col_q  <= '0;
				dcol_q <= '0;
				if (row_wrap) begin
					row_q  <= '0;
					drow_q <= '0;
				end else begin
					row_q  <= row_q + ROW_W'(1);
					drow_q <= drow_q + (row_q[0] ? DROW_W'(1) : DROW_W'(2));
				end
			end else begin
				col_q  <= col_q + COL_W'(1);
				dcol_q <= dcol_q + DCOL_W'(3);
			end
		end
	end

`ifndef SYNTHESIS
	a_col_origin: assert property (@(posedge clk) disable iff (!arst_n)
		col_q == '0 |-> dcol_q == '0)
		else $error("dest column out of step with source column");
	a_row_origin: assert property (@(posedge clk) disable iff (!arst_n)
		row_q == '0 |-> drow_q == '0)
		else $error("dest row out of step with source row");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(SRC_BYTES_PER_ROW - 1))
		else $error("source column past row end");
`endif
endmodule
`default_nettype wire

@@ sv/pus_fifo.sv @@
`default_nettype none
module pus_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire pus_pkg::item_t wr_item,
	input  wire logic           pop,
	output logic                full,
	output pus_pkg::head_t      head
);
	import pus_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

@@ sv/pus_back.sv @@
`default_nettype none
module pus_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pus_pkg::head_t head,
	output logic                pop,
	pus_out_if.source           out_ch
);
	import pus_pkg::*;

	logic [1:0]        j_q;
	logic              rep_q;
	logic              ovalid_q;
	logic [7:0]        obyte_q;
	logic [DROW_W-1:0] orow_q;
	logic [DCOL_W-1:0] ocol_q;
	logic              olast_q;
	logic              load, is_last;
	logic [7:0]        sel_byte;

	assign load    = head.valid & (~ovalid_q | out_ch.ready);
	assign is_last = (j_q == 2'd2) & (rep_q | ~head.item.dbl);
	assign pop     = load & is_last;

	always_comb begin
		case (j_q)
			2'd0: sel_byte = head.item.b0;
			2'd1: sel_byte = head.item.b1;
			default: sel_byte = head.item.b2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q      <= '0;
			rep_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else if (load) begin
			ovalid_q <= 1'b1;
			if (is_last) begin
				j_q   <= '0;
				rep_q <= 1'b0;
			end else if (j_q == 2'd2) begin
				j_q   <= '0;
				rep_q <= 1'b1;
			end else begin
				j_q <= j_q + 2'd1;
			end
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			obyte_q <= sel_byte;
			orow_q  <= head.item.row + DROW_W'(rep_q);
			ocol_q  <= head.item.col + DCOL_W'(j_q);
			olast_q <= is_last;
		end
	end

	assign out_ch.valid    = ovalid_q;
	assign out_ch.out_byte = obyte_q;
	assign out_ch.out_row  = orow_q;
	assign out_ch.out_col  = ocol_q;
	assign out_ch.last     = olast_q;

`ifndef SYNTHESIS
	a_j_range: assert property (@(posedge clk) disable iff (!arst_n)
		j_q != 2'd3)
		else $error("byte index out of range");
	a_rep_dbl: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q |-> head.valid && head.item.dbl)
		else $error("second row pass on an undoubled or missing item");
	a_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		(j_q != 2'd0 || rep_q) |-> head.valid)
		else $error("item left the queue before its last word");
`endif
endmodule
`default_nettype wire

@@ sv/pixel_upscale_three_halves.sv @@
// An accepted word is written into the queue, and its bytes then pass through the output register.
// Throughput: the back-end sequencer issues one output word per cycle while the output is not stalled;
//   each input word yields six output words on even source rows and three on odd rows.
// A 2-entry queue lets the front accept while the back is busy or stalled.
// Reset: counters, queue and output valid clear; palette returns to 15/10/5/0.
`default_nettype none
module pixel_upscale_three_halves (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	pus_in_if.sink                              in_ch,
	pus_out_if.source                           out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [pus_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [pus_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pus_pkg::*;

	logic  push, pop, full;
	item_t push_item;
	head_t head;

	// Front: palette lookup, byte packing and destination placement
	pus_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.full      (full),
		.push      (push),
		.item      (push_item)
	);

	// Queue: decouple acceptance from emission
	pus_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.pop     (pop),
		.full    (full),
		.head    (head)
	);

	// Back: walk three bytes, twice on doubled rows, into the output register
	pus_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);
endmodule
`default_nettype wire
